### src/fres_pkg.sv
// shared constants and sideband types for the fresnel reflectance pipeline
`timescale 1ns / 1ps
`default_nettype none
package fres_pkg;

  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
  // 0.999999 in Q.28
  localparam logic [28:0] TIR_LIM = 29'd268435188;
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [41:0] ONE_Q40 = 42'h100_0000_0000;
  localparam logic [42:0] HALF_LSB = 43'h200_0000;

  typedef struct packed {
    logic [13:0] n1;
    logic [13:0] n2;
    logic [28:0] cos_a;
  } fres_side_t;

  typedef struct packed {
    logic        tir;
    logic [13:0] n1;
    logic [13:0] n2;
    logic [28:0] cos_a;
  } fres_tside_t;

endpackage
`default_nettype wire

### src/dielectric_fresnel_reflectance.sv
// Unpolarized fresnel reflectance at a dielectric boundary, fully pipelined.
// Query channel: query_valid/query_stall with the normal and incoming direction
// (signed Q1.14) and the two refractive indices (Q2.12). Result channel:
// result_valid/result_stall with reflectance (Q1.15, 32768 = 1.0) and
// total_internal, set when total internal reflection forces the result to one.
// One query is accepted every cycle while query_stall is low. Each result
// passes through 4 front stages, a 29 stage root for the sine of incidence,
// 2 reflection test stages, a 29 stage divider for the refracted sine,
// 2 squaring stages, a 29 stage root for the refracted cosine, 2 ratio setup
// stages, two parallel 21 stage ratio dividers, 2 output stages and the
// output register. The depth comes from these one-bit-per-stage roots and dividers.
// A two-entry output skid holds results while the receiver stalls; when its
// spare entry fills, query_stall rises and the whole pipeline holds, so nothing
// is lost or repeated. Reset clears all valid bits and the skid; no result
// is pending after reset and query_stall is low.
`timescale 1ns / 1ps
`default_nettype none
module dielectric_fresnel_reflectance (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               query_valid,
  output logic                    query_stall,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic signed [15:0] dir_z,
  input  wire logic [13:0]        index_in,
  input  wire logic [13:0]        index_out,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [15:0]             reflectance,
  output logic                    total_internal
);
  import fres_pkg::*;

  logic en;

  // front
  logic        f_v;
  logic [57:0] f_rad;
  fres_side_t  f_side;

  // sine of incidence
  logic        a_v;
  logic [28:0] sin_a;
  logic [$bits(fres_side_t)-1:0] a_side_bits;
  fres_side_t  a_side;

  // reflection test
  logic        t1_v, t2_v;
  logic [42:0] t1_p, t1_q;
  fres_side_t  t1_side;
  fres_tside_t t2_side;
  logic [13:0] t2_rem0;
  logic [28:0] t2_low;

  // refracted sine
  logic        b_v;
  logic [28:0] sin_b;
  logic [$bits(fres_tside_t)-1:0] b_side_bits;
  fres_tside_t b_side;
  logic [28:0] sin_bc;
  logic [57:0] sq2_full;
  logic        c1_v, c2_v;
  logic [28:0] c1_sq, c2_x;
  fres_tside_t c1_side, c2_side;

  // refracted cosine
  logic        d_v;
  logic [28:0] cos_b;
  logic [$bits(fres_tside_t)-1:0] d_side_bits;
  fres_tside_t d_side;

  // amplitude ratios
  logic        r1_v, r2_v, r1_tir, r2_tir;
  logic [42:0] r1_as, r1_bs, r1_ap, r1_bp;
  logic [42:0] num_s, num_p;
  logic [43:0] den_s, den_p;
  logic [43:0] r2_rem0_s, r2_rem0_p, r2_den_s, r2_den_p;
  logic [20:0] r2_low_s, r2_low_p;
  logic        r2_zero_s, r2_zero_p;

  logic        q_v, q_vp;
  logic [20:0] q_s, q_p;
  logic [1:0]  q_side_s;
  logic        q_side_p;

  // output stages
  logic        s1_v, s1_tir, s2_v, s2_tir;
  logic [41:0] s1_rs2, s1_rp2;
  logic [42:0] sum;
  logic [15:0] s2_res;

  // skid
  logic        spare_v, spare_tir;
  logic [15:0] spare_res;
  logic        push;

  assign en          = !spare_v;
  assign query_stall = spare_v;

  fres_front u_front (
    .clk, .rst, .en,
    .in_valid (query_valid),
    .normal_x, .normal_y, .normal_z, .dir_x, .dir_y, .dir_z,
    .index_in, .index_out,
    .out_valid (f_v),
    .radicand  (f_rad),
    .side_out  (f_side)
  );

  fres_sqrt_pipe #(.RW(29), .SW($bits(fres_side_t))) u_sqrt_a (
    .clk, .rst, .en,
    .in_valid (f_v),
    .radicand (f_rad),
    .side_in  (f_side),
    .out_valid(a_v),
    .root     (sin_a),
    .side_out (a_side_bits)
  );
  assign a_side = fres_side_t'(a_side_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else if (en) begin
      t1_v    <= a_v;
      t1_p    <= 43'(a_side.n1) * 43'(sin_a);
      t1_q    <= 43'(TIR_LIM) * 43'(a_side.n2);
      t1_side <= a_side;
      t2_v    <= t1_v;
      t2_side <= '{tir: (t1_side.n2 == 14'd0) || (t1_p > t1_q),
                   n1: t1_side.n1, n2: t1_side.n2, cos_a: t1_side.cos_a};
      t2_rem0 <= t1_p[42:29];
      t2_low  <= t1_p[28:0];
    end
  end

  fres_div_pipe #(.VW(14), .QW(29), .SW($bits(fres_tside_t))) u_div_sin (
    .clk, .rst, .en,
    .in_valid (t2_v),
    .rem0     (t2_rem0),
    .low      (t2_low),
    .divisor  (t2_side.n2),
    .side_in  (t2_side),
    .out_valid(b_v),
    .quot     (sin_b),
    .side_out (b_side_bits)
  );
  assign b_side = fres_tside_t'(b_side_bits);

  always_comb begin
    sin_bc   = (sin_b > ONE_Q28) ? ONE_Q28 : sin_b;
    sq2_full = 58'(sin_bc) * 58'(sin_bc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (en) begin
      c1_v    <= b_v;
      c1_sq   <= sq2_full[56:28];
      c1_side <= b_side;
      c2_v    <= c1_v;
      c2_x    <= ONE_Q28 - c1_sq;
      c2_side <= c1_side;
    end
  end

  fres_sqrt_pipe #(.RW(29), .SW($bits(fres_tside_t))) u_sqrt_b (
    .clk, .rst, .en,
    .in_valid (c2_v),
    .radicand ({1'b0, c2_x, 28'd0}),
    .side_in  (c2_side),
    .out_valid(d_v),
    .root     (cos_b),
    .side_out (d_side_bits)
  );
  assign d_side = fres_tside_t'(d_side_bits);

  always_comb begin
    num_s = (r1_as > r1_bs) ? r1_as - r1_bs : r1_bs - r1_as;
    num_p = (r1_ap > r1_bp) ? r1_ap - r1_bp : r1_bp - r1_ap;
    den_s = 44'(r1_as) + 44'(r1_bs);
    den_p = 44'(r1_ap) + 44'(r1_bp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
    end else if (en) begin
      r1_v      <= d_v;
      r1_tir    <= d_side.tir;
      r1_as     <= 43'(d_side.n1) * 43'(d_side.cos_a);
      r1_bs     <= 43'(d_side.n2) * 43'(cos_b);
      r1_ap     <= 43'(d_side.n2) * 43'(d_side.cos_a);
      r1_bp     <= 43'(d_side.n1) * 43'(cos_b);
      r2_v      <= r1_v;
      r2_tir    <= r1_tir;
      // dividend is num << 20 and the quotient fits 21 bits
      r2_rem0_s <= {2'b00, num_s[42:1]};
      r2_rem0_p <= {2'b00, num_p[42:1]};
      r2_low_s  <= {num_s[0], 20'd0};
      r2_low_p  <= {num_p[0], 20'd0};
      r2_den_s  <= den_s;
      r2_den_p  <= den_p;
      r2_zero_s <= den_s == 44'd0;
      r2_zero_p <= den_p == 44'd0;
    end
  end

  fres_div_pipe #(.VW(44), .QW(21), .SW(2)) u_div_rs (
    .clk, .rst, .en,
    .in_valid (r2_v),
    .rem0     (r2_rem0_s),
    .low      (r2_low_s),
    .divisor  (r2_den_s),
    .side_in  ({r2_tir, r2_zero_s}),
    .out_valid(q_v),
    .quot     (q_s),
    .side_out (q_side_s)
  );

  fres_div_pipe #(.VW(44), .QW(21), .SW(1)) u_div_rp (
    .clk, .rst, .en,
    .in_valid (r2_v),
    .rem0     (r2_rem0_p),
    .low      (r2_low_p),
    .divisor  (r2_den_p),
    .side_in  (r2_zero_p),
    .out_valid(q_vp),
    .quot     (q_p),
    .side_out (q_side_p)
  );

  always_comb begin
    sum = 43'(s1_rs2) + 43'(s1_rp2) + HALF_LSB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v   <= q_v && q_vp;
      s1_tir <= q_side_s[1];
      s1_rs2 <= q_side_s[0] ? ONE_Q40 : 42'(q_s) * 42'(q_s);
      s1_rp2 <= q_side_p ? ONE_Q40 : 42'(q_p) * 42'(q_p);
      s2_v   <= s1_v;
      s2_tir <= s1_tir;
      if (s1_tir || sum[42:26] > 17'(ONE_Q15)) begin
        s2_res <= ONE_Q15;
      end else begin
        s2_res <= sum[41:26];
      end
    end
  end

  assign push = en && s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_v      <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (spare_v) begin
        result_valid   <= 1'b1;
        reflectance    <= spare_res;
        total_internal <= spare_tir;
        spare_v        <= 1'b0;
      end else begin
        result_valid   <= push;
        reflectance    <= s2_res;
        total_internal <= s2_tir;
      end
    end else if (push) begin
      spare_v   <= 1'b1;
      spare_res <= s2_res;
      spare_tir <= s2_tir;
    end
  end

endmodule
`default_nettype wire

### src/fres_sqrt_pipe.sv
// pipelined floor square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fres_sqrt_pipe #(
  parameter int RW = 29,
  parameter int SW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*RW-1:0]   radicand,
  input  wire logic [SW-1:0]     side_in,
  output logic                   out_valid,
  output logic [RW-1:0]          root,
  output logic [SW-1:0]          side_out
);

  logic            vld_q  [1:RW];
  logic [RW+1:0]   rem_q  [1:RW];
  logic [RW-1:0]   root_q [1:RW];
  logic [2*RW-1:0] rad_q  [1:RW];
  logic [SW-1:0]   side_q [1:RW];

  logic            cur_vld  [0:RW-1];
  logic [RW+1:0]   cur_rem  [0:RW-1];
  logic [RW-1:0]   cur_root [0:RW-1];
  logic [2*RW-1:0] cur_rad  [0:RW-1];
  logic [SW-1:0]   cur_side [0:RW-1];

  logic [RW+3:0]   trial    [0:RW-1];
  logic [RW+3:0]   sub      [0:RW-1];
  logic            take     [0:RW-1];
  logic [RW+1:0]   nxt_rem  [0:RW-1];
  logic [RW-1:0]   nxt_root [0:RW-1];

  always_comb begin
    cur_vld[0]  = in_valid;
    cur_rem[0]  = '0;
    cur_root[0] = '0;
    cur_rad[0]  = radicand;
    cur_side[0] = side_in;
    for (int k = 1; k < RW; k++) begin
      cur_vld[k]  = vld_q[k];
      cur_rem[k]  = rem_q[k];
      cur_root[k] = root_q[k];
      cur_rad[k]  = rad_q[k];
      cur_side[k] = side_q[k];
    end
    for (int k = 0; k < RW; k++) begin
      trial[k]    = {cur_rem[k], cur_rad[k][2*RW-1 -: 2]};
      sub[k]      = {2'b00, cur_root[k], 2'b01};
      take[k]     = trial[k] >= sub[k];
      nxt_rem[k]  = take[k] ? (RW+2)'(trial[k] - sub[k]) : (RW+2)'(trial[k]);
      nxt_root[k] = {cur_root[k][RW-2:0], take[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= RW; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < RW; k++) begin
        vld_q[k+1]  <= cur_vld[k];
        rem_q[k+1]  <= nxt_rem[k];
        root_q[k+1] <= nxt_root[k];
        rad_q[k+1]  <= {cur_rad[k][2*RW-3:0], 2'b00};
        side_q[k+1] <= cur_side[k];
      end
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = root_q[RW];
  assign side_out  = side_q[RW];

endmodule
`default_nettype wire

### src/fres_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fres_div_pipe #(
  parameter int VW = 14,
  parameter int QW = 29,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [VW-1:0] rem0,
  input  wire logic [QW-1:0] low,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      side_out
);

  logic          vld_q  [1:QW];
  logic [VW-1:0] rem_q  [1:QW];
  logic [QW-1:0] ql_q   [1:QW];
  logic [VW-1:0] d_q    [1:QW];
  logic [SW-1:0] side_q [1:QW];

  logic          cur_vld  [0:QW-1];
  logic [VW-1:0] cur_rem  [0:QW-1];
  logic [QW-1:0] cur_ql   [0:QW-1];
  logic [VW-1:0] cur_d    [0:QW-1];
  logic [SW-1:0] cur_side [0:QW-1];

  logic [VW:0]   trial [0:QW-1];
  logic [VW:0]   diff  [0:QW-1];
  logic          ge    [0:QW-1];

  always_comb begin
    cur_vld[0]  = in_valid;
    cur_rem[0]  = rem0;
    cur_ql[0]   = low;
    cur_d[0]    = divisor;
    cur_side[0] = side_in;
    for (int k = 1; k < QW; k++) begin
      cur_vld[k]  = vld_q[k];
      cur_rem[k]  = rem_q[k];
      cur_ql[k]   = ql_q[k];
      cur_d[k]    = d_q[k];
      cur_side[k] = side_q[k];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k] = {cur_rem[k], cur_ql[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, cur_d[k]};
      ge[k]    = trial[k] >= {1'b0, cur_d[k]};
    end
  end

  // dividend bits leave at the top of ql while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= QW; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) begin
        vld_q[k+1]  <= cur_vld[k];
        rem_q[k+1]  <= ge[k] ? diff[k][VW-1:0] : trial[k][VW-1:0];
        ql_q[k+1]   <= {cur_ql[k][QW-2:0], ge[k]};
        d_q[k+1]    <= cur_d[k];
        side_q[k+1] <= cur_side[k];
      end
    end
  end

  assign out_valid = vld_q[QW];
  assign quot      = ql_q[QW];
  assign side_out  = side_q[QW];

endmodule
`default_nettype wire

### src/fres_front.sv
// dot product, cosine of incidence and sine radicand
`timescale 1ns / 1ps
`default_nettype none
module fres_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic signed [15:0] dir_z,
  input  wire logic [13:0]        index_in,
  input  wire logic [13:0]        index_out,
  output logic                    out_valid,
  output logic [57:0]             radicand,
  output fres_pkg::fres_side_t    side_out
);
  import fres_pkg::*;

  logic               v1, v2, v3, v4;
  logic signed [31:0] p0, p1, p2;
  logic [13:0]        n1_1, n2_1;
  fres_side_t         side2, side3, side4;
  logic [28:0]        sq3, x4;

  logic signed [33:0] dot;
  logic [33:0]        mag;
  logic [28:0]        cos_next;
  logic [57:0]        sq_full;

  always_comb begin
    dot = {{2{p0[31]}}, p0} + {{2{p1[31]}}, p1} + {{2{p2[31]}}, p2};
    mag = dot[33] ? 34'(-dot) : 34'(dot);
    cos_next = (mag > 34'(ONE_Q28)) ? ONE_Q28 : mag[28:0];
    sq_full = 58'(side2.cos_a) * 58'(side2.cos_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      p0 <= normal_x * dir_x;
      p1 <= normal_y * dir_y;
      p2 <= normal_z * dir_z;
      n1_1 <= index_in;
      n2_1 <= index_out;
      side2 <= '{n1: n1_1, n2: n2_1, cos_a: cos_next};
      side3 <= side2;
      sq3 <= sq_full[56:28];
      side4 <= side3;
      x4 <= ONE_Q28 - sq3;
    end
  end

  assign out_valid = v4;
  assign radicand  = {1'b0, x4, 28'd0};
  assign side_out  = side4;

endmodule
`default_nettype wire

### src/fres_checker.sv
// port-level checks for the fresnel reflectance block
`timescale 1ns / 1ps
`default_nettype none
module fres_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        query_valid,
  input wire logic        query_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [15:0] reflectance,
  input wire logic        total_internal
);
  import fres_pkg::*;

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !query_stall)
    else $error("result or stall pending after reset");

  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    result_valid && total_internal |-> reflectance == ONE_Q15)
    else $error("total reflection beat without full reflectance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> reflectance <= ONE_Q15)
    else $error("reflectance above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(query_stall) |-> $past(result_valid && result_stall))
    else $error("query stall without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(reflectance)
      && $stable(total_internal))
    else $error("stalled result beat changed");

endmodule

bind dielectric_fresnel_reflectance fres_checker u_fres_checker (.*);
`default_nettype wire

### dv/fresnel_checker.sv
// beat monitor, reflectance predictor and result checker for the fresnel block
`timescale 1ns / 1ps
module fresnel_checker
  import fres_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  input  logic               query_stall,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [13:0]        index_in,
  input  logic [13:0]        index_out,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [15:0]        reflectance,
  input  logic               total_internal,
  output int                 err_count,
  output int                 pending
);

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } refl_t;

  refl_t refl_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // squared amplitude ratio in Q.40
  function automatic longint unsigned amp_ratio_sq(longint unsigned a, longint unsigned b);
    longint unsigned num;
    longint unsigned den;
    longint unsigned r;
    num = (a > b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd1 << 40;
    r = (num << 20) / den;
    return r * r;
  endfunction

  function automatic refl_t fresnel_reflect(
    logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
    logic signed [15:0] ix, logic signed [15:0] iy, logic signed [15:0] iz,
    logic [13:0] i1, logic [13:0] i2);
    longint          dot;
    longint unsigned one;
    longint unsigned n1;
    longint unsigned n2;
    longint unsigned cos_a;
    longint unsigned sin_a;
    longint unsigned sin_b;
    longint unsigned cos_b;
    longint unsigned sq;
    longint unsigned sum;
    refl_t           r;
    one = 64'(ONE_Q28);
    dot = longint'(nx) * longint'(ix) + longint'(ny) * longint'(iy)
        + longint'(nz) * longint'(iz);
    n1 = 64'(i1);
    n2 = 64'(i2);
    cos_a = (dot < 0) ? longint'(-dot) : longint'(dot);
    if (cos_a > one) cos_a = one;
    sq = (cos_a * cos_a) >> 28;
    sin_a = floor_root((one - sq) << 28);
    if (n2 == 0 || n1 * sin_a > 64'(TIR_LIM) * n2) begin
      r.refl = ONE_Q15;
      r.tir = 1'b1;
      return r;
    end
    sin_b = (n1 * sin_a) / n2;
    if (sin_b > one) sin_b = one;
    sq = (sin_b * sin_b) >> 28;
    cos_b = floor_root((one - sq) << 28);
    sum = amp_ratio_sq(n1 * cos_a, n2 * cos_b) + amp_ratio_sq(n2 * cos_a, n1 * cos_b);
    sum = (sum + (64'd1 << 25)) >> 26;
    if (sum > 64'(ONE_Q15)) sum = 64'(ONE_Q15);
    r.refl = sum[15:0];
    r.tir = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    refl_t want;
    if (!rst) begin
      if (query_valid && !query_stall)
        refl_q.push_back(fresnel_reflect(normal_x, normal_y, normal_z,
                                         dir_x, dir_y, dir_z, index_in, index_out));
      if (result_valid && !result_stall) begin
        if (refl_q.size() == 0) begin
          report_mismatch("unexpected result beat", reflectance, -1);
        end else begin
          want = refl_q.pop_front();
          if (reflectance !== want.refl)
            report_mismatch("reflectance", reflectance, want.refl);
          if (total_internal !== want.tir)
            report_mismatch("total_internal", total_internal, want.tir);
        end
      end
    end
    pending = refl_q.size();
  end

endmodule

### dv/tb.sv
// stimulus and verdict for the fresnel reflectance block
`timescale 1ns / 1ps
module tb;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               query_valid = 1'b0;
  logic               query_stall;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic signed [15:0] dir_x = '0;
  logic signed [15:0] dir_y = '0;
  logic signed [15:0] dir_z = '0;
  logic [13:0]        index_in = 14'd4096;
  logic [13:0]        index_out = 14'd4096;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [15:0]        reflectance;
  logic               total_internal;
  int                 err_count;
  int                 pending;
  int                 cycles = 0;
  logic               quiet_phase = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dielectric_fresnel_reflectance i_dut (.*);

  fresnel_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall: bursts of short stalls, rare long ones, and clean stretches
  initial begin
    int run;
    @(negedge clk);
    while (1) begin
      run = $urandom_range(1, 40);
      if (quiet_phase || $urandom_range(0, 3) == 0) begin
        repeat (run) @(negedge clk) result_stall <= 1'b0;
      end else begin
        repeat (run) begin
          @(negedge clk);
          if ($urandom_range(0, 19) == 0)
            result_stall <= 1'b1;
          else
            result_stall <= ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(10, 30)) @(negedge clk) result_stall <= 1'b1;
      end
    end
  end

  // called at a falling edge; leaves on the falling edge after acceptance
  task automatic send_query(int nx, int ny, int nz, int ix, int iy, int iz,
                            int i1, int i2);
    logic taken;
    query_valid <= 1'b1;
    normal_x <= 16'(nx);
    normal_y <= 16'(ny);
    normal_z <= 16'(nz);
    dir_x <= 16'(ix);
    dir_y <= 16'(iy);
    dir_z <= 16'(iz);
    index_in <= 14'(i1);
    index_out <= 14'(i2);
    do begin
      taken = !query_stall;
      @(posedge clk);
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic sender_gap();
    int n;
    if (quiet_phase || $urandom_range(0, 2) != 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    query_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic int rand_comp();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic int rand_index();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(4096, 16383)
                                       : $urandom_range(4096, 8192);
  endfunction

  // random direction scaled to unit length in Q1.14
  task automatic unit_vec(output int x, output int y, output int z);
    real a, b, c, len;
    do begin
      a = $itor(rand_comp());
      b = $itor(rand_comp());
      c = $itor(rand_comp());
      len = $sqrt(a * a + b * b + c * c);
    end while (len < 100.0);
    x = $rtoi(a / len * 16384.0);
    y = $rtoi(b / len * 16384.0);
    z = $rtoi(c / len * 16384.0);
  endtask

  initial begin
    int nx, ny, nz, ix, iy, iz;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // normal incidence, both senses
    send_query(16384, 0, 0, 16384, 0, 0, 4096, 6144);
    send_query(16384, 0, 0, -16384, 0, 0, 6144, 4096);
    send_query(0, -16384, 0, 0, 16384, 0, 16383, 4096);
    // grazing incidence, dense into thin gives total internal reflection
    send_query(0, 0, 16384, 16384, 0, 0, 16383, 4096);
    send_query(0, 0, 16384, 16384, 0, 0, 4096, 16383);
    send_query(0, 0, 16384, 16384, 0, 0, 4096, 4096);
    // equal indices
    send_query(11585, 11585, 0, 16384, 0, 0, 8192, 8192);
    // oblique, just around the critical angle for n1/n2 = 2
    send_query(16384, 0, 0, 14189, 8192, 0, 8192, 4096);
    send_query(16384, 0, 0, 14190, 8191, 0, 8192, 4096);
    send_query(16384, 0, 0, 14188, 8193, 0, 8192, 4096);
    // oversized vectors clamp the cosine
    send_query(16384, 16384, 16384, 16384, 16384, 16384, 16383, 16383);
    send_query(-16384, -16384, -16384, 16384, 16384, 16384, 4096, 16383);
    send_query(-16384, 16384, -16384, -16384, -16384, -16384, 16383, 4096);
    // zero vectors act as grazing incidence
    send_query(0, 0, 0, 0, 0, 0, 4096, 16383);
    send_query(0, 0, 0, 0, 0, 0, 16383, 16383);
    send_query(-1, 1, -1, 1, -1, 1, 12345, 5000);
    send_query(9459, 9459, 9459, -9459, 9459, -9459, 6000, 6001);

    // hold until the pipeline drains
    query_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 200 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
          ix = rand_comp(); iy = rand_comp(); iz = rand_comp();
        end
        default: begin
          unit_vec(nx, ny, nz);
          unit_vec(ix, iy, iz);
        end
      endcase
      send_query(nx, ny, nz, ix, iy, iz, rand_index(), rand_index());
      sender_gap();
    end
    query_valid <= 1'b0;
    quiet_phase = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
src/fres_pkg.sv
src/fres_sqrt_pipe.sv
src/fres_div_pipe.sv
src/fres_front.sv
src/dielectric_fresnel_reflectance.sv
src/fres_checker.sv
dv/fresnel_checker.sv
dv/tb.sv
